[sv/sife_pkg.sv]
package sife_pkg;

    localparam int MAX_SIDE_DEF = 64;
    localparam int OP_W         = 3;
    localparam int PIX_W        = 8;
    localparam int POS_W        = 6;
    localparam int SIDE_W       = 7;

    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 3'd0,
        OP_LOAD   = 3'd1,
        OP_DIM    = 3'd2,
        OP_BRIGHT = 3'd3,
        OP_ROTATE = 3'd4,
        OP_CROP   = 3'd5,
        OP_READ   = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SWEEP,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

[sv/sife_ram.sv]
module sife_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/square_image_frame_editor_top.sv]
// Start load, load pixel, rejected, empty-image ops: result next cycle; 1 word/cycle if no stall.
// Read pixel: the frame store read is registered, then the result is registered at the output.
// Dim, brighten, crop: one pixel per cycle in place over the image or crop window, then the result;
// rotate: one pass into the scratch bank and one back.
// Input stalls while an operation is in progress or a result waits under stall.
// Reset (synchronous, active low): side and load count to zero; pixels stay undefined.
module square_image_frame_editor_top #(
    parameter int MAX_SIDE = sife_pkg::MAX_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [sife_pkg::OP_W-1:0]   i_operation,
    input  logic [sife_pkg::PIX_W-1:0]  i_pixel_value,
    input  logic [sife_pkg::POS_W-1:0]  i_row,
    input  logic [sife_pkg::POS_W-1:0]  i_col,
    input  logic [sife_pkg::SIDE_W-1:0] i_new_side,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [sife_pkg::PIX_W-1:0]  o_pixel_out,
    output logic                        o_status,
    output logic [sife_pkg::SIDE_W-1:0] o_side_now
);

    import sife_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int AXW   = AW + SIDE_W;
    localparam logic [SIDE_W+1:0] MAX_SIDE_V = (SIDE_W+2)'(MAX_SIDE);

    function automatic logic [AW-1:0] f_addr(input logic [SIDE_W-1:0] r,
                                             input logic [SIDE_W-1:0] c);
        logic [AXW-1:0] w;
        w = AXW'(r) * AXW'(MAX_SIDE) + AXW'(c);
        return w[AW-1:0];
    endfunction

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [SIDE_W-1:0]  r_n, n_n;
    logic [SIDE_W-1:0]  r_r0, n_r0;
    logic [SIDE_W-1:0]  r_c0, n_c0;
    logic [SIDE_W-1:0]  r_sr, n_sr;
    logic [SIDE_W-1:0]  r_sc, n_sc;
    logic               r_pv, n_pv;
    logic [SIDE_W-1:0]  r_pr, n_pr;
    logic [SIDE_W-1:0]  r_pc, n_pc;
    logic               r_bank, n_bank;
    logic [SIDE_W-1:0]  r_side, n_side;
    logic [SIDE_W-1:0]  r_ld_row, n_ld_row;
    logic [SIDE_W-1:0]  r_ld_col, n_ld_col;
    logic               r_ov, n_ov;
    logic [PIX_W-1:0]   r_opix, n_opix;
    logic               r_ost, n_ost;
    logic [SIDE_W-1:0]  r_oside, n_oside;

    logic               out_free;
    logic               accept;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic               mem_we;
    logic               mem_wbank;
    logic [AW-1:0]      mem_waddr;
    logic [PIX_W-1:0]   mem_wdata;
    logic [PIX_W-1:0]   q0, q1, rd_data;
    logic [PIX_W-1:0]   adj_data;
    logic [SIDE_W-1:0]  dst_row, dst_col;
    logic [SIDE_W+1:0]  crop_row_end, crop_col_end;

    sife_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (mem_we && !mem_wbank),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (q0)
    );

    sife_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (mem_we && mem_wbank),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (q1)
    );

    assign rd_data  = r_bank ? q1 : q0;
    assign out_free = !r_ov || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign accept   = i_valid && !o_stall;

    assign crop_row_end = (SIDE_W+2)'(i_row) + (SIDE_W+2)'(i_new_side);
    assign crop_col_end = (SIDE_W+2)'(i_col) + (SIDE_W+2)'(i_new_side);

    always_comb begin
        case (r_op)
            OP_DIM:    adj_data = (rd_data == PIX_MIN) ? PIX_MIN : rd_data - 8'd1;
            OP_BRIGHT: adj_data = (rd_data == PIX_MAX) ? PIX_MAX : rd_data + 8'd1;
            default:   adj_data = rd_data;
        endcase
        if (r_op == OP_ROTATE && !r_bank) begin
            dst_row = r_pc;
            dst_col = r_n - 7'd1 - r_pr;
        end else begin
            dst_row = r_pr;
            dst_col = r_pc;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_n      = r_n;
        n_r0     = r_r0;
        n_c0     = r_c0;
        n_sr     = r_sr;
        n_sc     = r_sc;
        n_pv     = r_pv;
        n_pr     = r_pr;
        n_pc     = r_pc;
        n_bank   = r_bank;
        n_side   = r_side;
        n_ld_row = r_ld_row;
        n_ld_col = r_ld_col;
        n_ov     = r_ov;
        n_opix   = r_opix;
        n_ost    = r_ost;
        n_oside  = r_oside;

        mem_re    = 1'b0;
        mem_raddr = f_addr(r_r0 + r_sr, r_c0 + r_sc);
        mem_we    = 1'b0;
        mem_wbank = (r_op == OP_ROTATE) && !r_bank;
        mem_waddr = f_addr(dst_row, dst_col);
        mem_wdata = adj_data;

        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ov    = 1'b1;
                    n_opix  = PIX_MIN;
                    n_ost   = 1'b1;
                    n_oside = r_side;
                    unique case (t_op'(i_operation))
                        OP_START: begin
                            if (i_new_side != '0 && (SIDE_W+2)'(i_new_side) <= MAX_SIDE_V) begin
                                n_side   = i_new_side;
                                n_ld_row = '0;
                                n_ld_col = '0;
                                n_ost    = 1'b0;
                                n_oside  = i_new_side;
                            end
                        end
                        OP_LOAD: begin
                            if (r_side != '0 && r_ld_row < r_side) begin
                                mem_we    = 1'b1;
                                mem_wbank = 1'b0;
                                mem_waddr = f_addr(r_ld_row, r_ld_col);
                                mem_wdata = i_pixel_value;
                                n_ost     = 1'b0;
                                if (r_ld_col == r_side - 7'd1) begin
                                    n_ld_col = '0;
                                    n_ld_row = r_ld_row + 7'd1;
                                end else begin
                                    n_ld_col = r_ld_col + 7'd1;
                                end
                            end
                        end
                        OP_DIM, OP_BRIGHT, OP_ROTATE: begin
                            if (r_side == '0) begin
                                n_ost = 1'b0;
                            end else begin
                                n_ov    = r_ov && i_stall;
                                n_op    = t_op'(i_operation);
                                n_n     = r_side;
                                n_r0    = '0;
                                n_c0    = '0;
                                n_sr    = '0;
                                n_sc    = '0;
                                n_pv    = 1'b0;
                                n_bank  = 1'b0;
                                n_state = S_SWEEP;
                            end
                        end
                        OP_CROP: begin
                            if (i_new_side != '0 && crop_row_end <= (SIDE_W+2)'(r_side)
                                    && crop_col_end <= (SIDE_W+2)'(r_side)) begin
                                n_ov    = r_ov && i_stall;
                                n_op    = OP_CROP;
                                n_n     = i_new_side;
                                n_r0    = SIDE_W'(i_row);
                                n_c0    = SIDE_W'(i_col);
                                n_sr    = '0;
                                n_sc    = '0;
                                n_pv    = 1'b0;
                                n_bank  = 1'b0;
                                n_state = S_SWEEP;
                            end
                        end
                        OP_READ: begin
                            if (SIDE_W'(i_row) < r_side && SIDE_W'(i_col) < r_side) begin
                                n_ov      = r_ov && i_stall;
                                mem_re    = 1'b1;
                                mem_raddr = f_addr(SIDE_W'(i_row), SIDE_W'(i_col));
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                            n_ost = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_opix  = rd_data;
                    n_ost   = 1'b0;
                    n_oside = r_side;
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                mem_re = 1'b1;
                mem_we = r_pv;
                n_pv   = 1'b1;
                n_pr   = r_sr;
                n_pc   = r_sc;
                if (r_sc == r_n - 7'd1) begin
                    n_sc = '0;
                    if (r_sr == r_n - 7'd1) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_sr = r_sr + 7'd1;
                    end
                end else begin
                    n_sc = r_sc + 7'd1;
                end
            end
            S_DRAIN: begin
                mem_we = 1'b1;
                n_pv   = 1'b0;
                if (r_op == OP_ROTATE && !r_bank) begin
                    n_bank  = 1'b1;
                    n_sr    = '0;
                    n_sc    = '0;
                    n_state = S_SWEEP;
                end else begin
                    n_bank = 1'b0;
                    if (r_op == OP_CROP) begin
                        n_side   = r_n;
                        n_ld_row = r_n;
                        n_ld_col = '0;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_opix  = PIX_MIN;
                    n_ost   = 1'b0;
                    n_oside = r_side;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pv     <= 1'b0;
            r_bank   <= 1'b0;
            r_side   <= '0;
            r_ld_row <= '0;
            r_ld_col <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pv     <= n_pv;
            r_bank   <= n_bank;
            r_side   <= n_side;
            r_ld_row <= n_ld_row;
            r_ld_col <= n_ld_col;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_n     <= n_n;
        r_r0    <= n_r0;
        r_c0    <= n_c0;
        r_sr    <= n_sr;
        r_sc    <= n_sc;
        r_pr    <= n_pr;
        r_pc    <= n_pc;
        r_opix  <= n_opix;
        r_ost   <= n_ost;
        r_oside <= n_oside;
    end

    assign o_valid     = r_ov;
    assign o_pixel_out = r_opix;
    assign o_status    = r_ost;
    assign o_side_now  = r_oside;

endmodule
